// File: rtl/fodm_pkg.sv
// Shared constants and types for the field-oriented omni drive mixer.
`timescale 1ns / 1ps

package fodm_pkg;

	// number formats
	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 14;
	localparam int ONE        = 1 << FRAC_BITS;

	// sine polynomial coefficients and 1/sqrt2, all Q15
	localparam int SIN_A      = 51472;
	localparam int SIN_B      = 21024;
	localparam int SIN_C      = 2320;
	localparam int HALF_ROOT2 = 23170;
	localparam int DUTY_MAX   = 255;

	// datapath widths
	localparam int SPD_W = 15;                 // clamped speed
	localparam int MAG_W = 17;                 // sine magnitude, up to 32768
	localparam int W_W   = 18;                 // signed wheel term
	localparam int A_W   = W_W - 1;            // wheel term magnitude
	localparam int Q_W   = FRAC_BITS + 1;      // normalized magnitude, up to ONE
	localparam int PR_W  = Q_W + 8 + SPD_W;    // magnitude * 255 * speed cap
	localparam int DM_W  = (PR_W - 2 * FRAC_BITS > 8) ? PR_W - 2 * FRAC_BITS : 8;
	localparam int RS_W  = DM_W + 16 - FRAC_BITS;

	// register map
	typedef enum logic [2:0] {
		REG_SPEED_CAP  = 3'd0,
		REG_YAW_NEGATE = 3'd1,
		REG_GAIN_1     = 3'd2,
		REG_GAIN_2     = 3'd3,
		REG_GAIN_3     = 3'd4,
		REG_GAIN_4     = 3'd5,
		REG_MIN_DUTY   = 3'd6
	} fodm_reg_t;

	// control that travels with each beat
	typedef struct packed {
		logic vld;
		logic stop;
	} fodm_tag_t;

	// payload that rides along the sine/cosine pipe
	typedef struct packed {
		logic [SPD_W-1:0] spd;
		logic [15:0]      rot;
	} fodm_side_t;

endpackage

// File: rtl/fodm_cmd_if.sv
// Drive command channel.
`timescale 1ns / 1ps

interface fodm_cmd_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] heading;
	logic [15:0] yaw;
	logic [15:0] speed;
	logic [15:0] rotation;

	modport source (output valid, func, heading, yaw, speed, rotation, input ready);
	modport sink (input valid, func, heading, yaw, speed, rotation, output ready);
endinterface

// File: rtl/fodm_duty_if.sv
// Motor duty result channel.
`timescale 1ns / 1ps

interface fodm_duty_if;
	logic       valid;
	logic       ready;
	logic [7:0] m1_fwd;
	logic [7:0] m1_rev;
	logic [7:0] m2_fwd;
	logic [7:0] m2_rev;
	logic [7:0] m3_fwd;
	logic [7:0] m3_rev;
	logic [7:0] m4_fwd;
	logic [7:0] m4_rev;

	modport source (output valid, m1_fwd, m1_rev, m2_fwd, m2_rev, m3_fwd, m3_rev,
		m4_fwd, m4_rev, input ready);
	modport sink (input valid, m1_fwd, m1_rev, m2_fwd, m2_rev, m3_fwd, m3_rev,
		m4_fwd, m4_rev, output ready);
endinterface

// File: rtl/fodm_cfg_if.sv
// Configuration register write channel.
`timescale 1ns / 1ps

interface fodm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/fodm_trig.sv
// Five-stage sine and cosine pipeline (quarter-wave fifth-order polynomial).
`timescale 1ns / 1ps

module fodm_trig import fodm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  fodm_tag_t                 tag_i,
	input  logic [ANGLE_BITS-1:0]     ang_i,
	input  fodm_side_t                side_i,
	output fodm_tag_t                 tag_o,
	output fodm_side_t                side_o,
	output logic [1:0][MAG_W-1:0]     mag_o,   // lane 0 sine, lane 1 cosine
	output logic [1:0]                neg_o
);

	logic [31:0]       turn;
	logic [1:0][1:0]   quad;
	logic [14:0]       frac;
	logic [1:0][15:0]  z_d;

	fodm_tag_t tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	fodm_side_t side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [1:0][15:0] z_s2, z_s3, z_s4, z_s5;
	logic [1:0][15:0] zz_s3, zz_s4;
	logic [1:0][14:0] inner_s4;
	logic [1:0][15:0] mid_s5;
	logic [1:0][MAG_W-1:0] mag_s6;
	logic [1:0] n_s2, n_s3, n_s4, n_s5, n_s6;

	// fold the angle into the first quadrant; cosine is a quarter turn ahead
	always_comb begin
		turn    = {ang_i, (32 - ANGLE_BITS)'(0)};
		quad[0] = turn[31:30];
		quad[1] = turn[31:30] + 2'd1;
		frac    = turn[29:15];
		for (int l = 0; l < 2; l++) begin
			z_d[l] = quad[l][0] ? 16'(17'd32768 - 17'(frac)) : 16'(frac);
		end
	end

	// beat valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else if (en) begin
			tag_s2 <= tag_i;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	// polynomial: z2 = z*z, inner = b - z2*c, mid = a - z2*inner, s = z*mid
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_i;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			for (int l = 0; l < 2; l++) begin
				z_s2[l]     <= z_d[l];
				n_s2[l]     <= quad[l][1];
				z_s3[l]     <= z_s2[l];
				zz_s3[l]    <= 16'((32'(z_s2[l]) * 32'(z_s2[l])) >> 15);
				n_s3[l]     <= n_s2[l];
				z_s4[l]     <= z_s3[l];
				zz_s4[l]    <= zz_s3[l];
				inner_s4[l] <= 15'(32'(SIN_B) - ((32'(zz_s3[l]) * 32'(SIN_C)) >> 15));
				n_s4[l]     <= n_s3[l];
				z_s5[l]     <= z_s4[l];
				mid_s5[l]   <= 16'(32'(SIN_A) - ((32'(zz_s4[l]) * 32'(inner_s4[l])) >> 15));
				n_s5[l]     <= n_s4[l];
				mag_s6[l]   <= MAG_W'((32'(z_s5[l]) * 32'(mid_s5[l])) >> 15);
				n_s6[l]     <= n_s5[l];
			end
		end
	end

	assign tag_o  = tag_s6;
	assign side_o = side_s6;
	assign mag_o  = mag_s6;
	assign neg_o  = n_s6;

endmodule

// File: rtl/fodm_div.sv
// Pipelined restoring divider: |w| * ONE / m, one quotient bit per stage, four lanes.
`timescale 1ns / 1ps

module fodm_div import fodm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  fodm_tag_t              tag_i,
	input  logic                   big_i,
	input  logic [A_W-1:0]         m_i,
	input  logic [3:0][A_W-1:0]    a_i,
	input  logic [3:0][W_W-1:0]    w_i,
	output fodm_tag_t              tag_o,
	output logic                   big_o,
	output logic [3:0][Q_W-1:0]    q_o,
	output logic [3:0][W_W-1:0]    w_o
);

	fodm_tag_t              tag_s [Q_W];
	logic                   big_s [Q_W];
	logic [A_W-1:0]         m_s   [Q_W];
	logic [3:0][A_W-1:0]    rem_s [Q_W];
	logic [3:0][Q_W-1:0]    quo_s [Q_W];
	logic [3:0][W_W-1:0]    w_s   [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		fodm_tag_t           tag_in;
		logic                big_in;
		logic [A_W-1:0]      m_in;
		logic [3:0][A_W:0]   trial;
		logic [3:0][Q_W-1:0] q_in;
		logic [3:0][W_W-1:0] w_in;
		logic [3:0]          take;
		logic [3:0][A_W-1:0] rem_d;
		logic [3:0][Q_W-1:0] quo_d;

		// stage inputs: ports for the first stage, previous stage otherwise
		if (k == 0) begin : g_first
			assign tag_in = tag_i;
			assign big_in = big_i;
			assign m_in   = m_i;
			assign q_in   = '0;
			assign w_in   = w_i;
			for (genvar l = 0; l < 4; l++) begin : g_lane
				assign trial[l] = {1'b0, a_i[l]};
			end
		end else begin : g_next
			assign tag_in = tag_s[k-1];
			assign big_in = big_s[k-1];
			assign m_in   = m_s[k-1];
			assign q_in   = quo_s[k-1];
			assign w_in   = w_s[k-1];
			for (genvar l = 0; l < 4; l++) begin : g_lane
				assign trial[l] = {rem_s[k-1][l], 1'b0};
			end
		end

		// compare and subtract; remainder stays below m
		always_comb begin
			for (int l = 0; l < 4; l++) begin
				take[l]  = trial[l] >= {1'b0, m_in};
				rem_d[l] = take[l] ? A_W'(trial[l] - {1'b0, m_in}) : A_W'(trial[l]);
				quo_d[l] = {q_in[l][Q_W-2:0], take[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				big_s[k] <= big_in;
				m_s[k]   <= m_in;
				rem_s[k] <= rem_d;
				quo_s[k] <= quo_d;
				w_s[k]   <= w_in;
			end
		end
	end

	assign tag_o = tag_s[Q_W-1];
	assign big_o = big_s[Q_W-1];
	assign q_o   = quo_s[Q_W-1];
	assign w_o   = w_s[Q_W-1];

endmodule

// File: rtl/fodm_out.sv
// Duty scaling, dead-band lift, motor gain, clamp and forward/reverse split.
`timescale 1ns / 1ps

module fodm_out import fodm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  fodm_tag_t              tag_i,
	input  logic                   big_i,
	input  logic [3:0][Q_W-1:0]    q_i,      // per motor
	input  logic [3:0][W_W-1:0]    w_i,      // per motor
	input  logic [SPD_W-1:0]       speed_cap,
	input  logic [7:0]             min_duty,
	input  logic [3:0][15:0]       gain,
	output fodm_tag_t              tag_o,
	output logic [3:0][7:0]        fwd_o,
	output logic [3:0][7:0]        rev_o
);

	fodm_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [3:0]               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [3:0][Q_W+7:0]      xm_s1;
	logic [3:0][PR_W-1:0]     prod_s2;
	logic [3:0][DM_W-1:0]     lm_s3;
	logic [3:0][RS_W-1:0]     res_s4;
	logic [3:0][7:0]          fwd_s5, rev_s5;

	logic [3:0][Q_W-1:0]      mag_d;
	logic [3:0]               wneg_d;
	logic [3:0][DM_W-1:0]     dm_d;
	logic [3:0][DM_W-1:0]     lm_d;
	logic [3:0][15:0]         gm_d;
	logic [3:0][DM_W+15:0]    pm_d;
	logic [3:0][7:0]          cm_d;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			// normalized magnitude: quotient when scaled down, else the term's own magnitude
			wneg_d[l] = w_i[l][W_W-1];
			if (big_i) begin
				mag_d[l] = q_i[l];
			end else begin
				mag_d[l] = wneg_d[l] ? Q_W'(-$signed(w_i[l])) : Q_W'(w_i[l]);
			end
			// duty magnitude and dead-band lift
			dm_d[l] = DM_W'(prod_s2[l] >> (2 * FRAC_BITS));
			if (dm_d[l] != '0 && dm_d[l] < DM_W'(min_duty)) begin
				lm_d[l] = DM_W'(min_duty);
			end else begin
				lm_d[l] = dm_d[l];
			end
			// gain magnitude
			gm_d[l] = gain[l][15] ? 16'(-17'($signed(gain[l]))) : gain[l];
			pm_d[l] = (DM_W + 16)'(lm_s3[l]) * (DM_W + 16)'(gm_d[l]);
			// clamp
			cm_d[l] = (32'(res_s4[l]) > DUTY_MAX) ? 8'(DUTY_MAX) : 8'(res_s4[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (en) begin
			tag_s1 <= tag_i;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				neg_s1[l]  <= wneg_d[l];
				xm_s1[l]   <= {mag_d[l], 8'b0} - (Q_W + 8)'(mag_d[l]);
				neg_s2[l]  <= neg_s1[l];
				prod_s2[l] <= PR_W'(xm_s1[l]) * PR_W'(speed_cap);
				neg_s3[l]  <= neg_s2[l];
				lm_s3[l]   <= lm_d[l];
				neg_s4[l]  <= neg_s3[l] ^ gain[l][15];
				res_s4[l]  <= RS_W'(pm_d[l] >> FRAC_BITS);
				fwd_s5[l]  <= (tag_s4.stop || neg_s4[l]) ? 8'd0 : cm_d[l];
				rev_s5[l]  <= (!tag_s4.stop && neg_s4[l]) ? cm_d[l] : 8'd0;
			end
		end
	end

	assign tag_o = tag_s5;
	assign fwd_o = fwd_s5;
	assign rev_o = rev_s5;

endmodule

// File: rtl/field_oriented_omni_drive_mixer_core.sv
// Top level of the field-oriented four-wheel omni drive mixer.
`timescale 1ns / 1ps

// Takes one drive command per clock and returns the four motor duty pairs.
// Every stage holds under a stall on the duty channel, so the sustained rate
// is one command per cycle whenever the sink keeps ready high. The depth
// spans the front, sine/cosine (five stages), mixing, divider and output
// stages; the normalizing divider resolves one quotient bit per stage.
// Configuration writes are always accepted and take effect at once; change
// them only while no command is in flight.
module field_oriented_omni_drive_mixer_core import fodm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fodm_cmd_if.sink      cmd,
	fodm_duty_if.source   duty,
	fodm_cfg_if.sink      cfg
);

	logic                   en;
	logic [SPD_W-1:0]       speed_cap_q;
	logic                   yaw_negate_q;
	logic [3:0][15:0]       motor_gain_q;
	logic [7:0]             min_duty_q;

	// front stage
	logic signed [31:0]     hd_ext, yw_ext, yw_comp, diff;
	logic [SPD_W-1:0]       spd_d;
	fodm_tag_t              tag_s1;
	logic [ANGLE_BITS-1:0]  ang_s1;
	fodm_side_t             side_s1;

	// sine / cosine
	fodm_tag_t              tag_s6;
	fodm_side_t             side_s6;
	logic [1:0][MAG_W-1:0]  mag_s6;
	logic [1:0]             neg_s6;

	// mixing stages
	logic [1:0][15:0]       vm_d;
	fodm_tag_t              tag_s7, tag_s8, tag_s9, tag_s10;
	logic signed [16:0]     vx_s7, vy_s7;
	logic [15:0]            rot_s7, rot_s8;
	logic signed [W_W-1:0]  d_d [2];
	logic [A_W-1:0]         ad_d [2];
	logic [A_W-1:0]         pm_d [2];
	logic [1:0][W_W-1:0]    p_s8;
	logic [3:0][W_W-1:0]    w_d, w_s9, w_s10;
	logic [3:0][A_W-1:0]    a_d, a_s9, a_s10;
	logic [A_W-1:0]         m01_d, m23_d, m_d, m_s10;
	logic                   big_s10;

	// divider and output
	fodm_tag_t              tag_dv, tag_o;
	logic                   big_dv;
	logic [3:0][Q_W-1:0]    q_dv, q_mot;
	logic [3:0][W_W-1:0]    w_dv, w_mot;
	logic [3:0][7:0]        fwd, rev;

	// whole pipe advances unless a finished beat is stuck at the output
	assign en        = !tag_o.vld || duty.ready;
	assign cmd.ready = en;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_cap_q  <= SPD_W'(16384);
			yaw_negate_q <= 1'b0;
			motor_gain_q <= {4{16'd16384}};
			min_duty_q   <= 8'd35;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SPEED_CAP:  speed_cap_q     <= cfg.data[SPD_W-1:0];
				REG_YAW_NEGATE: yaw_negate_q    <= cfg.data[0];
				REG_GAIN_1:     motor_gain_q[0] <= cfg.data;
				REG_GAIN_2:     motor_gain_q[1] <= cfg.data;
				REG_GAIN_3:     motor_gain_q[2] <= cfg.data;
				REG_GAIN_4:     motor_gain_q[3] <= cfg.data;
				REG_MIN_DUTY:   min_duty_q      <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// heading compensation and speed clamp
	always_comb begin
		hd_ext  = 32'($signed(cmd.heading));
		yw_ext  = 32'($signed(cmd.yaw));
		yw_comp = yaw_negate_q ? -yw_ext : yw_ext;
		diff    = hd_ext - yw_comp;
		if (cmd.speed[15]) begin
			spd_d = '0;
		end else if (cmd.speed[14:0] > speed_cap_q) begin
			spd_d = speed_cap_q;
		end else begin
			spd_d = cmd.speed[14:0];
		end
	end

	// resolve speed, rotate by 45 degrees, add rotation, take magnitudes
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			vm_d[l] = 16'((32'(side_s6.spd) * 32'(mag_s6[l])) >> 15);
		end
		d_d[0] = W_W'(vy_s7) - W_W'(vx_s7);
		d_d[1] = W_W'(vx_s7) + W_W'(vy_s7);
		for (int l = 0; l < 2; l++) begin
			ad_d[l] = d_d[l][W_W-1] ? A_W'(-d_d[l]) : A_W'(d_d[l]);
			pm_d[l] = A_W'((32'(ad_d[l]) * 32'(HALF_ROOT2)) >> 15);
		end
		w_d[0] = W_W'($signed(rot_s8)) + $signed(p_s8[0]);
		w_d[1] = W_W'($signed(rot_s8)) + $signed(p_s8[1]);
		w_d[2] = W_W'($signed(rot_s8)) - $signed(p_s8[0]);
		w_d[3] = W_W'($signed(rot_s8)) - $signed(p_s8[1]);
		for (int l = 0; l < 4; l++) begin
			a_d[l] = w_d[l][W_W-1] ? A_W'(-$signed(w_d[l])) : A_W'(w_d[l]);
		end
		m01_d = (a_s9[0] > a_s9[1]) ? a_s9[0] : a_s9[1];
		m23_d = (a_s9[2] > a_s9[3]) ? a_s9[2] : a_s9[3];
		m_d   = (m01_d > m23_d) ? m01_d : m23_d;
	end

	// beat valid bits of the front and mixing stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			tag_s7  <= '0;
			tag_s8  <= '0;
			tag_s9  <= '0;
			tag_s10 <= '0;
		end else if (en) begin
			tag_s1  <= '{vld: cmd.valid, stop: cmd.func};
			tag_s7  <= tag_s6;
			tag_s8  <= tag_s7;
			tag_s9  <= tag_s8;
			tag_s10 <= tag_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1      <= diff[ANGLE_BITS-1:0];
			side_s1.spd <= spd_d;
			side_s1.rot <= cmd.rotation;
			vy_s7       <= neg_s6[0] ? -$signed({1'b0, vm_d[0]}) : $signed({1'b0, vm_d[0]});
			vx_s7       <= neg_s6[1] ? -$signed({1'b0, vm_d[1]}) : $signed({1'b0, vm_d[1]});
			rot_s7      <= side_s6.rot;
			rot_s8      <= rot_s7;
			for (int l = 0; l < 2; l++) begin
				p_s8[l] <= d_d[l][W_W-1] ? -$signed({1'b0, pm_d[l]}) : $signed({1'b0, pm_d[l]});
			end
			w_s9    <= w_d;
			a_s9    <= a_d;
			w_s10   <= w_s9;
			a_s10   <= a_s9;
			m_s10   <= m_d;
			big_s10 <= 32'(m_d) > ONE;
		end
	end

	fodm_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (tag_s1),
		.ang_i  (ang_s1),
		.side_i (side_s1),
		.tag_o  (tag_s6),
		.side_o (side_s6),
		.mag_o  (mag_s6),
		.neg_o  (neg_s6)
	);

	fodm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (tag_s10),
		.big_i  (big_s10),
		.m_i    (m_s10),
		.a_i    (a_s10),
		.w_i    (w_s10),
		.tag_o  (tag_dv),
		.big_o  (big_dv),
		.q_o    (q_dv),
		.w_o    (w_dv)
	);

	// motors 3 and 4 take wheel terms three and two
	assign q_mot = {q_dv[2], q_dv[3], q_dv[1], q_dv[0]};
	assign w_mot = {w_dv[2], w_dv[3], w_dv[1], w_dv[0]};

	fodm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tag_i     (tag_dv),
		.big_i     (big_dv),
		.q_i       (q_mot),
		.w_i       (w_mot),
		.speed_cap (speed_cap_q),
		.min_duty  (min_duty_q),
		.gain      (motor_gain_q),
		.tag_o     (tag_o),
		.fwd_o     (fwd),
		.rev_o     (rev)
	);

	assign duty.valid  = tag_o.vld;
	assign duty.m1_fwd = fwd[0];
	assign duty.m1_rev = rev[0];
	assign duty.m2_fwd = fwd[1];
	assign duty.m2_rev = rev[1];
	assign duty.m3_fwd = fwd[2];
	assign duty.m3_rev = rev[2];
	assign duty.m4_fwd = fwd[3];
	assign duty.m4_rev = rev[3];

`ifndef SYNTH
	// a stop beat leaves every motor idle
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tag_o.vld && tag_o.stop |-> fwd == '0 && rev == '0)
		else $error("stop beat drives a motor");

	// a motor is never driven both ways
	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		duty.valid |-> (fwd[0] == 8'd0 || rev[0] == 8'd0) && (fwd[1] == 8'd0 || rev[1] == 8'd0)
			&& (fwd[2] == 8'd0 || rev[2] == 8'd0) && (fwd[3] == 8'd0 || rev[3] == 8'd0))
		else $error("forward and reverse both active");

	// a write to an unused index changes nothing
	a_cfg_unused: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && cfg.index > REG_MIN_DUTY |=>
			$stable(speed_cap_q) && $stable(min_duty_q) && $stable(motor_gain_q)
			&& $stable(yaw_negate_q))
		else $error("unused register index altered configuration");
`endif

endmodule

// File: tb/sv/fodm_tb_if.sv
// Testbench-side note: the channel interfaces live with the RTL; this file holds shared tb types.
`timescale 1ns / 1ps

package fodm_tb_pkg;
	// one expected duty set
	typedef struct packed {
		logic [7:0] m1_fwd;
		logic [7:0] m1_rev;
		logic [7:0] m2_fwd;
		logic [7:0] m2_rev;
		logic [7:0] m3_fwd;
		logic [7:0] m3_rev;
		logic [7:0] m4_fwd;
		logic [7:0] m4_rev;
	} duty_set_t;
endpackage

// File: tb/sv/field_oriented_omni_drive_mixer_core_test.sv
// Self-checking testbench for the field-oriented omni drive mixer core.
`timescale 1ns / 1ps

module field_oriented_omni_drive_mixer_core_test;
	import fodm_pkg::*;
	import fodm_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	longint cycles = 0;
	int   src_idle = 0;
	int   snk_idle = 0;
	int   n_in = 0;
	int   n_out = 0;
	int   n_stop = 0;

	// shadow of the configuration
	logic [14:0]        sh_speed_cap = 15'd16384;
	logic               sh_yaw_negate = 1'b0;
	logic signed [15:0] sh_gain [4] = '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
	logic [7:0]         sh_min_duty = 8'd35;

	fodm_cmd_if  cmd ();
	fodm_duty_if duty ();
	fodm_cfg_if  cfg ();

	field_oriented_omni_drive_mixer_core uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .duty(duty.source), .cfg(cfg.sink)
	);

	always #5 clk = ~clk;

	// truncating shift toward zero
	function automatic longint shift_tz(longint p, int sh);
		if (p < 0) return -((-p) >>> sh);
		return p >>> sh;
	endfunction

	// Q15 quarter-wave polynomial sine of a 32-bit angle
	function automatic longint poly_sin(logic [31:0] t);
		longint f, z, z2, inner, mid, s;
		f = longint'((t >> 15) & 32'h7fff);
		z = t[30] ? 32768 - f : f;
		z2 = (z * z) >>> 15;
		inner = SIN_B - ((z2 * SIN_C) >>> 15);
		mid = SIN_A - ((z2 * inner) >>> 15);
		s = (z * mid) >>> 15;
		return t[31] ? -s : s;
	endfunction

	// dead band, gain, clamp and split of one wheel
	function automatic void wheel_pins(longint d, longint g,
		output logic [7:0] fwd, output logic [7:0] rev);
		longint md;
		md = longint'(sh_min_duty);
		if (d > 0 && d < md) d = md;
		else if (d < 0 && d > -md) d = -md;
		d = shift_tz(d * g, FRAC_BITS);
		if (d > 255) d = 255;
		if (d < -255) d = -255;
		fwd = d > 0 ? 8'(d) : 8'd0;
		rev = d < 0 ? 8'(-d) : 8'd0;
	endfunction

	function automatic duty_set_t mix_command(logic fn, logic [15:0] hd, logic [15:0] yw,
		logic [15:0] sp, logic [15:0] rt);
		duty_set_t r;
		longint yaw_v, spd, rot, vx, vy, m, a, dt [4], w [4];
		logic [15:0] ang;
		logic [31:0] t;
		r = '0;
		if (fn) return r;
		yaw_v = longint'($signed(yw));
		spd = longint'($signed(sp));
		rot = longint'($signed(rt));
		if (spd < 0) spd = 0;
		if (spd > longint'(sh_speed_cap)) spd = longint'(sh_speed_cap);
		if (sh_yaw_negate) yaw_v = -yaw_v;
		ang = 16'(longint'($signed(hd)) - yaw_v);
		t = {ang, 16'h0};
		vx = shift_tz(spd * poly_sin(t + 32'h4000_0000), 15);
		vy = shift_tz(spd * poly_sin(t), 15);
		w[0] = shift_tz((vy - vx) * HALF_ROOT2, 15) + rot;
		w[1] = shift_tz((vx + vy) * HALF_ROOT2, 15) + rot;
		w[2] = shift_tz((vx - vy) * HALF_ROOT2, 15) + rot;
		w[3] = shift_tz(-(vx + vy) * HALF_ROOT2, 15) + rot;
		m = 0;
		for (int i = 0; i < 4; i++) begin
			a = w[i] < 0 ? -w[i] : w[i];
			if (a > m) m = a;
		end
		if (m > ONE)
			for (int i = 0; i < 4; i++) w[i] = (w[i] * ONE) / m;
		for (int i = 0; i < 4; i++)
			dt[i] = shift_tz(w[i] * 255 * longint'(sh_speed_cap), 2 * FRAC_BITS);
		wheel_pins(dt[0], sh_gain[0], r.m1_fwd, r.m1_rev);
		wheel_pins(dt[1], sh_gain[1], r.m2_fwd, r.m2_rev);
		wheel_pins(dt[3], sh_gain[2], r.m3_fwd, r.m3_rev);
		wheel_pins(dt[2], sh_gain[3], r.m4_fwd, r.m4_rev);
		return r;
	endfunction

	task automatic report(string msg);
		errors++;
		$display("mismatch @%0t: %s", $time, msg);
	endtask

	// pending duty sets, oldest first
	class duty_board;
		duty_set_t pending [$];
		function void note_command(duty_set_t d);
			pending.push_back(d);
		endfunction
		task check_duty(duty_set_t got);
			duty_set_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected duty beat %h", got));
				return;
			end
			e = pending.pop_front();
			if (got.m1_fwd !== e.m1_fwd) report($sformatf("m1_fwd %0d exp %0d", got.m1_fwd, e.m1_fwd));
			if (got.m1_rev !== e.m1_rev) report($sformatf("m1_rev %0d exp %0d", got.m1_rev, e.m1_rev));
			if (got.m2_fwd !== e.m2_fwd) report($sformatf("m2_fwd %0d exp %0d", got.m2_fwd, e.m2_fwd));
			if (got.m2_rev !== e.m2_rev) report($sformatf("m2_rev %0d exp %0d", got.m2_rev, e.m2_rev));
			if (got.m3_fwd !== e.m3_fwd) report($sformatf("m3_fwd %0d exp %0d", got.m3_fwd, e.m3_fwd));
			if (got.m3_rev !== e.m3_rev) report($sformatf("m3_rev %0d exp %0d", got.m3_rev, e.m3_rev));
			if (got.m4_fwd !== e.m4_fwd) report($sformatf("m4_fwd %0d exp %0d", got.m4_fwd, e.m4_fwd));
			if (got.m4_rev !== e.m4_rev) report($sformatf("m4_rev %0d exp %0d", got.m4_rev, e.m4_rev));
		endtask
	endclass

	duty_board board = new();

	initial begin
		cmd.valid = 1'b0; cmd.func = 1'b0; cmd.heading = '0; cmd.yaw = '0;
		cmd.speed = '0; cmd.rotation = '0;
		cfg.valid = 1'b0; cfg.index = REG_SPEED_CAP; cfg.data = '0;
		duty.ready = 1'b0;
	end

	// receiver side: random stalls, check every accepted beat
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAIL");
			$finish;
		end
		if (arst_n) begin
			if (duty.valid && duty.ready) begin
				board.check_duty('{duty.m1_fwd, duty.m1_rev, duty.m2_fwd, duty.m2_rev,
					duty.m3_fwd, duty.m3_rev, duty.m4_fwd, duty.m4_rev});
				n_out++;
			end
			duty.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// one command beat, predicted on acceptance
	task automatic send_cmd(logic fn, logic [15:0] hd, logic [15:0] yw,
		logic [15:0] sp, logic [15:0] rt);
		while ($urandom_range(99) < src_idle) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1; cmd.func <= fn; cmd.heading <= hd; cmd.yaw <= yw;
		cmd.speed <= sp; cmd.rotation <= rt;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		board.note_command(mix_command(fn, hd, yw, sp, rt));
		n_in++;
		if (fn) n_stop++;
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// register write; only while idle
	task automatic write_reg(fodm_reg_t idx, logic [15:0] val);
		cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_SPEED_CAP:  sh_speed_cap = val[14:0];
			REG_YAW_NEGATE: sh_yaw_negate = val[0];
			REG_GAIN_1:     sh_gain[0] = val;
			REG_GAIN_2:     sh_gain[1] = val;
			REG_GAIN_3:     sh_gain[2] = val;
			REG_GAIN_4:     sh_gain[3] = val;
			REG_MIN_DUTY:   sh_min_duty = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic random_cmd();
		logic [15:0] sp, rt;
		case ($urandom_range(3))
			0: sp = 16'($urandom);
			1: sp = 16'($urandom_range(32767));
			default: sp = 16'($urandom_range(20000));
		endcase
		rt = $urandom_range(1) ? 16'($urandom) : 16'($signed($urandom_range(8000)) - 4000);
		send_cmd($urandom_range(15) == 0, 16'($urandom), 16'($urandom), sp, rt);
	endtask

	// random setting, with extremes mixed in
	task automatic random_config();
		write_reg(REG_SPEED_CAP, $urandom_range(3) == 0 ?
			($urandom_range(1) ? 16'd32767 : 16'd0) : 16'($urandom));
		write_reg(REG_YAW_NEGATE, 16'($urandom_range(1)));
		for (int g = 0; g < 4; g++)
			write_reg(fodm_reg_t'(REG_GAIN_1 + g), $urandom_range(4) == 0 ?
				($urandom_range(1) ? 16'h8000 : 16'h7fff) : 16'($urandom));
		write_reg(REG_MIN_DUTY, $urandom_range(3) == 0 ?
			($urandom_range(1) ? 16'd255 : 16'd0) : 16'($urandom_range(255)));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle = 29; snk_idle = 55;

		// directed: stop, zero, wrap, extremes, negative speed, tiny duties
		send_cmd(1'b1, 16'h1234, 16'h4321, 16'h4000, 16'h1000);
		send_cmd(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_cmd(1'b0, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
		send_cmd(1'b0, 16'h4000, 16'h0000, 16'h7fff, 16'h0000);
		send_cmd(1'b0, 16'h8000, 16'h7fff, 16'h4000, 16'h0000);
		send_cmd(1'b0, 16'h7fff, 16'h8000, 16'h2000, 16'h0000);
		send_cmd(1'b0, 16'hc000, 16'h4000, 16'h8000, 16'h0100);
		send_cmd(1'b0, 16'h2000, 16'h0000, 16'hffff, 16'h7fff);
		send_cmd(1'b0, 16'h2000, 16'h0000, 16'h4000, 16'h8000);
		send_cmd(1'b0, 16'h1000, 16'h0000, 16'h0010, 16'h0000);
		send_cmd(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0008);
		send_cmd(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hfff8);
		send_cmd(1'b0, 16'hffff, 16'hffff, 16'h3fff, 16'h4000);
		drain();
		write_reg(REG_YAW_NEGATE, 16'd1);
		write_reg(REG_GAIN_1, 16'h0000);
		write_reg(REG_GAIN_2, 16'h8000);
		write_reg(REG_GAIN_3, 16'h7fff);
		write_reg(REG_GAIN_4, 16'hc000);
		write_reg(REG_MIN_DUTY, 16'd255);
		write_reg(REG_SPEED_CAP, 16'd32767);
		send_cmd(1'b0, 16'h1000, 16'h2000, 16'h7fff, 16'h0000);
		send_cmd(1'b0, 16'h0000, 16'h0000, 16'h0001, 16'h0001);
		send_cmd(1'b0, 16'h6000, 16'ha000, 16'h4000, 16'hc000);
		drain();
		write_reg(REG_SPEED_CAP, 16'd0);
		write_reg(REG_MIN_DUTY, 16'd0);
		send_cmd(1'b0, 16'h1000, 16'h0000, 16'h4000, 16'h2000);
		send_cmd(1'b0, 16'h3000, 16'h0000, 16'h7fff, 16'h0000);
		drain();

		// random phases, with a new setting between each
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin src_idle = 55; snk_idle = 29; end
			if (ph == 8) begin src_idle = 0; snk_idle = 0; end
			random_config();
			for (int k = 0; k < 115; k++) begin
				random_cmd();
				if (k == 60) drain();
			end
			drain();
		end
		write_reg(REG_SPEED_CAP, 16'd16384);
		write_reg(REG_YAW_NEGATE, 16'd0);
		write_reg(REG_MIN_DUTY, 16'd35);
		for (int g = 0; g < 4; g++) write_reg(fodm_reg_t'(REG_GAIN_1 + g), 16'd16384);
		for (int k = 0; k < 150; k++) random_cmd();
		drain();

		$display("covered %0d commands (%0d stops), %0d duty beats checked", n_in, n_stop, n_out);
		$display("under reset, directed and random register settings, stalls on both sides");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
